[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/utf8bmp_pkg.sv]
`timescale 1ns / 1ps

package utf8bmp_pkg;

  localparam int ValueW   = 16;
  localparam int LenW     = 2;
  localparam int OutDataW = 24;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [LenW-1:0]   len_t;

  typedef enum logic {
    DIR_DECODE = 1'b0,
    DIR_ENCODE = 1'b1
  } dir_t;

  localparam len_t LenNone = 2'd0;
  localparam len_t Len1    = 2'd1;
  localparam len_t Len2    = 2'd2;
  localparam len_t Len3    = 2'd3;

  typedef struct packed {
    value_t value;
    logic   eos;
  } item_t;

  typedef struct packed {
    value_t value;
    len_t   len;
    logic   last;
    logic   broken;
  } res_t;

endpackage

[design/utf8bmp_in_stage.sv]
`timescale 1ns / 1ps

module utf8bmp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  utf8bmp_pkg::item_t  in_item,
  output logic                item_valid,
  output utf8bmp_pkg::item_t  item,
  input  logic                item_take
);
  import utf8bmp_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

[design/utf8bmp_core.sv]
`timescale 1ns / 1ps

module utf8bmp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                item_valid,
  input  utf8bmp_pkg::item_t  item,
  output logic                item_take,
  output logic                res_valid,
  output utf8bmp_pkg::res_t   res,
  input  logic                res_ready
);
  import utf8bmp_pkg::*;

  dir_t   dir_r;
  value_t pc_r, pc_nxt;
  logic [1:0] br_r, br_nxt;
  len_t   ss_r, ss_nxt;
  len_t   idx_r, idx_nxt;

  logic [7:0] b;
  value_t pc_merge;
  logic   dec_done;
  logic   dec_has;
  res_t   dec_res;

  value_t cp;
  len_t   enc_len;
  logic   enc_last;
  res_t   enc_res;

  logic   emit;

  assign b  = item.value[7:0];
  assign cp = item.value;

  assign pc_merge = pc_r | ((br_r == 2'd2) ? {4'b0, b[5:0], 6'b0} : {10'b0, b[5:0]});

  always_comb begin
    pc_nxt   = pc_r;
    br_nxt   = br_r;
    ss_nxt   = ss_r;
    dec_done = 1'b0;
    dec_has  = 1'b0;
    dec_res  = '{value: '0, len: LenNone, last: 1'b1, broken: 1'b0};
    if (br_r == 2'd0) begin
      if (b[7:5] == 3'b110) begin
        pc_nxt = {5'b0, b[4:0], 6'b0};
        br_nxt = 2'd1;
        ss_nxt = Len2;
      end else if (b[7:4] == 4'b1110) begin
        pc_nxt = {b[3:0], 12'b0};
        br_nxt = 2'd2;
        ss_nxt = Len3;
      end else begin
        dec_done      = 1'b1;
        dec_has       = 1'b1;
        dec_res.value = {8'b0, b};
        dec_res.len   = Len1;
      end
    end else begin
      pc_nxt = pc_merge;
      br_nxt = br_r - 2'd1;
      if (br_r == 2'd1) begin
        dec_done      = 1'b1;
        dec_has       = 1'b1;
        dec_res.value = pc_merge;
        dec_res.len   = ss_r;
        pc_nxt        = '0;
        ss_nxt        = LenNone;
      end
    end
    if (!dec_done && item.eos) begin
      pc_nxt         = '0;
      br_nxt         = 2'd0;
      ss_nxt         = LenNone;
      dec_has        = 1'b1;
      dec_res.value  = '0;
      dec_res.len    = LenNone;
      dec_res.broken = 1'b1;
    end
  end

  always_comb begin
    if (cp[15:11] != 5'd0) begin
      enc_len = Len3;
    end else if (cp[10:7] != 4'd0) begin
      enc_len = Len2;
    end else begin
      enc_len = Len1;
    end
  end

  assign enc_last = (idx_r == enc_len - Len1);

  always_comb begin
    enc_res = '{value: '0, len: enc_len, last: enc_last, broken: 1'b0};
    unique case (enc_len)
      Len1: enc_res.value = cp;
      Len2: enc_res.value = (idx_r == 2'd0) ? {8'b0, 3'b110, cp[10:6]}
                                            : {8'b0, 2'b10, cp[5:0]};
      Len3: begin
        case (idx_r)
          2'd0:    enc_res.value = {8'b0, 4'b1110, cp[15:12]};
          2'd1:    enc_res.value = {8'b0, 2'b10, cp[11:6]};
          default: enc_res.value = {8'b0, 2'b10, cp[5:0]};
        endcase
      end
      default: enc_res.value = '0;
    endcase
  end

  assign res       = (dir_r == DIR_ENCODE) ? enc_res : dec_res;
  assign res_valid = item_valid && ((dir_r == DIR_ENCODE) || dec_has);
  assign emit      = res_valid && res_ready;
  assign item_take = item_valid && ((dir_r == DIR_ENCODE) ? (res_ready && enc_last)
                                                          : (!dec_has || res_ready));

  assign idx_nxt = enc_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_DECODE;
    end else if (cfg_we) begin
      dir_r <= dir_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      br_r <= 2'd0;
      ss_r <= LenNone;
    end else if (item_take && (dir_r == DIR_DECODE)) begin
      pc_r <= pc_nxt;
      br_r <= br_nxt;
      ss_r <= ss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (emit && (dir_r == DIR_ENCODE)) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[design/utf8bmp_out_stage.sv]
`timescale 1ns / 1ps

module utf8bmp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  utf8bmp_pkg::res_t  res,
  output logic               res_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output utf8bmp_pkg::res_t  out_res
);
  import utf8bmp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

endmodule

[design/utf8_bmp_transcoder.sv]
`timescale 1ns / 1ps
// UTF-8 transcoder for one- to three-byte sequences.
// cfg_we/cfg_wdata write the direction: 0 decodes bytes to code points,
// 1 encodes code points to bytes. Write it only while the block is idle.
// Input words: in_tdata carries a byte (decode) or a code point (encode);
// in_tlast marks the final byte of a string in decode mode.
// Output words: out_tdata carries the code point or byte and the sequence
// length, out_tlast the final word of an input word, out_tuser a sequence
// cut off by end of string.
// An accepted word passes the input and the result register before its
// first result shows on out_tvalid. Decode takes one byte per cycle while
// out_tready is high; a lead or middle byte of an open sequence gives no
// result unless in_tlast cuts it off. Encode emits one to three bytes per
// code point and holds it until its last byte is taken. Reset clears the
// direction to decode and closes any open sequence. When out_tready is low
// the result register holds, the input register fills, and in_tready drops.
module utf8_bmp_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] value_res, [17:16] seq_length, [23:18] zero
  output logic        out_tlast,
  output logic        out_tuser   // [0] broken
);
  import utf8bmp_pkg::*;

  item_t in_item;
  logic  item_valid;
  item_t item;
  logic  item_take;
  logic  res_valid;
  res_t  res;
  logic  res_ready;
  res_t  out_res;

  assign in_item = '{value: in_tdata, eos: in_tlast};

  utf8bmp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  utf8bmp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  utf8bmp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {{(OutDataW - ValueW - LenW){1'b0}}, out_res.len, out_res.value};
  assign out_tlast = out_res.last;
  assign out_tuser = out_res.broken;

endmodule

[design/utf8bmp_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8bmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output word changed")
  `ASSERT_CLK(a_broken_shape, clk, rst_n, out_tvalid && out_tuser |-> out_tdata == 24'd0 && out_tlast, "cut-off result not empty and final")
  `ASSERT_CLK(a_mid_byte, clk, rst_n, out_tvalid && !out_tlast |-> out_tdata[7] && out_tdata[17] && !out_tuser, "non-final word is not a multi-byte lead or middle byte")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind utf8_bmp_transcoder utf8bmp_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[test/tb_utf8_bmp_transcoder.sv]
`timescale 1ns / 1ps

module tb_utf8_bmp_transcoder;
  import utf8bmp_pkg::*;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] value
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [15:0] value_res, [17:16] seq_length, [23:18] zero
  logic        out_tlast;
  logic        out_tuser;         // [0] broken

  utf8_bmp_transcoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // transcoder state as the block should hold it
  dir_t       model_dir = DIR_DECODE;
  value_t     acc_code  = '0;
  logic [1:0] awaiting  = 2'd0;
  len_t       seq_len   = LenNone;

  res_t awaited_units[$];
  int   mismatches  = 0;
  int   words_sent  = 0;
  bit   steady_flow = 1'b0;
  int   sink_hold   = 0;
  res_t got, want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_cycles();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic res_t code_unit(input value_t v, input len_t n, input logic lst,
                                     input logic brk);
    res_t r;
    r.value  = v;
    r.len    = n;
    r.last   = lst;
    r.broken = brk;
    return r;
  endfunction

  function automatic value_t pad_byte(input logic [7:0] b);
    logic [7:0] hi;
    hi = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
    return {hi, b};
  endfunction

  task automatic queue_unit(input res_t r);
    awaited_units = {awaited_units, r};
  endtask

  task automatic transcode_word(input value_t v, input logic eos);
    logic [7:0] b;
    b = v[7:0];
    if (model_dir == DIR_ENCODE) begin
      if (v < 16'h0080) begin
        queue_unit(code_unit(v, Len1, 1'b1, 1'b0));
      end else if (v < 16'h0800) begin
        queue_unit(code_unit({8'h00, 3'b110, v[10:6]}, Len2, 1'b0, 1'b0));
        queue_unit(code_unit({8'h00, 2'b10, v[5:0]}, Len2, 1'b1, 1'b0));
      end else begin
        queue_unit(code_unit({8'h00, 4'b1110, v[15:12]}, Len3, 1'b0, 1'b0));
        queue_unit(code_unit({8'h00, 2'b10, v[11:6]}, Len3, 1'b0, 1'b0));
        queue_unit(code_unit({8'h00, 2'b10, v[5:0]}, Len3, 1'b1, 1'b0));
      end
      return;
    end
    if (awaiting == 2'd0) begin
      if (b[7:5] == 3'b110) begin
        acc_code = {5'b0, b[4:0], 6'b0};
        awaiting = 2'd1;
        seq_len  = Len2;
      end else if (b[7:4] == 4'b1110) begin
        acc_code = {b[3:0], 12'b0};
        awaiting = 2'd2;
        seq_len  = Len3;
      end else begin
        queue_unit(code_unit({8'h00, b}, Len1, 1'b1, 1'b0));
        return;
      end
    end else begin
      acc_code = acc_code | ((awaiting == 2'd2) ? {4'b0, b[5:0], 6'b0} : {10'b0, b[5:0]});
      awaiting = awaiting - 2'd1;
      if (awaiting == 2'd0) begin
        queue_unit(code_unit(acc_code, seq_len, 1'b1, 1'b0));
        acc_code = '0;
        seq_len  = LenNone;
        return;
      end
    end
    if (eos) begin
      acc_code = '0;
      awaiting = 2'd0;
      seq_len  = LenNone;
      queue_unit(code_unit('0, LenNone, 1'b1, 1'b1));
    end
  endtask

  task automatic send_word(input value_t v, input logic eos);
    int gap;
    gap = (steady_flow || $urandom_range(0, 1)) ? 0 : gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    transcode_word(v, eos);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited_units.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_direction(input dir_t d);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_dir = d;
    @(posedge clk);
  endtask

  task automatic test_decode_directed();
    set_direction(DIR_DECODE);
    send_word(16'h0000, 1'b0); send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0); send_word(16'h00BF, 1'b0);
    send_word(16'h00F8, 1'b0); send_word(16'h00FF, 1'b0);
    send_word(16'hAB41, 1'b0);
    send_word(16'h00C2, 1'b0); send_word(16'h00A9, 1'b0);
    send_word(16'h00E2, 1'b0); send_word(16'h0082, 1'b0); send_word(16'h00AC, 1'b1);
    send_word(16'h00EF, 1'b0); send_word(16'hFFBF, 1'b0); send_word(16'h00BF, 1'b0);
    send_word(16'h00DF, 1'b0); send_word(16'h0041, 1'b0);
    send_word(16'h00C3, 1'b1);
    send_word(16'h00E0, 1'b0); send_word(16'h00A0, 1'b1);
    send_word(16'h0041, 1'b1); send_word(16'h00FF, 1'b1);
  endtask

  task automatic test_encode_directed();
    set_direction(DIR_ENCODE);
    send_word(16'h0000, 1'b0); send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0); send_word(16'h07FF, 1'b0);
    send_word(16'h0800, 1'b0); send_word(16'hD800, 1'b0);
    send_word(16'hDFFF, 1'b0); send_word(16'hFFFF, 1'b0);
    send_word(16'h1234, 1'b1); send_word(16'h00C0, 1'b1);
  endtask

  task automatic test_direction_keeps_state();
    set_direction(DIR_DECODE);
    send_word(16'h00E2, 1'b0);
    set_direction(DIR_ENCODE);
    send_word(16'h20AC, 1'b1);
    set_direction(DIR_DECODE);
    send_word(16'h0082, 1'b0);
    send_word(16'h00AC, 1'b0);
  endtask

  task automatic test_decode_random(input int count);
    int   stop_at;
    int   kind;
    logic eos;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      eos  = ($urandom_range(0, 5) == 0);
      case (kind)
        0, 1: send_word(pad_byte(8'($urandom_range(0, 127))), eos);
        2, 3: begin
          send_word(pad_byte({3'b110, 5'($urandom)}), 1'b0);
          send_word(pad_byte({2'b10, 6'($urandom)}), eos);
        end
        4, 5, 6: begin
          send_word(pad_byte({4'b1110, 4'($urandom)}), 1'b0);
          send_word(pad_byte({2'b10, 6'($urandom)}), 1'b0);
          send_word(pad_byte({2'b10, 6'($urandom)}), eos);
        end
        7: begin
          if ($urandom_range(0, 1)) begin
            send_word(pad_byte({3'b110, 5'($urandom)}), 1'b1);
          end else begin
            send_word(pad_byte({4'b1110, 4'($urandom)}), 1'b0);
            send_word(pad_byte({2'b10, 6'($urandom)}), 1'b1);
          end
        end
        default: send_word(value_t'($urandom), eos);
      endcase
    end
  endtask

  task automatic test_encode_random(input int count);
    int     i;
    value_t cp;
    set_direction(DIR_ENCODE);
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 5))
        0, 1:    cp = value_t'($urandom_range(0, 16'h007F));
        2, 3:    cp = value_t'($urandom_range(16'h0080, 16'h07FF));
        default: cp = value_t'($urandom);
      endcase
      send_word(cp, 1'($urandom));
    end
  endtask

  task automatic test_mixed_phases();
    set_direction(DIR_DECODE);
    test_decode_random(15);
    // hold input until the output side has emptied
    settle();
    test_decode_random(15);
    steady_flow = 1'b1;
    test_encode_random(15);
    set_direction(DIR_DECODE);
    test_decode_random(15);
    steady_flow = 1'b0;
    test_encode_random(10);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (steady_flow) begin
        out_tready <= 1'b1;
      end else if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold = gap_cycles();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = code_unit(out_tdata[15:0], out_tdata[17:16], out_tlast, out_tuser);
      if (awaited_units.size() == 0) begin
        $error("result word with none pending: value_res %h", got.value);
        mismatches++;
      end else begin
        want = awaited_units.pop_front();
        if (got.value !== want.value) begin
          $error("value_res: expected %h, got %h", want.value, got.value);
          mismatches++;
        end
        if (got.len !== want.len) begin
          $error("seq_length: expected %0d, got %0d", want.len, got.len);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, got.last);
          mismatches++;
        end
        if (got.broken !== want.broken) begin
          $error("broken: expected %b, got %b", want.broken, got.broken);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_decode_directed();
    test_encode_directed();
    test_direction_keeps_state();
    test_decode_random(90);
    test_encode_random(70);
    test_mixed_phases();
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
